@@ hdl/spc_pkg.sv @@
// spc_pkg: shared types and constants for the scan point curvature unit.
// Depends on nothing; compile before hdl/scan_point_curvature_unit.sv.

package spc_pkg;

  // Width of the reported curvature and its saturation value.
  localparam int CURV_W = 25;
  localparam logic [CURV_W-1:0] CURV_MAX = '1;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_START  = 7'b0000010,
    ST_READ   = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_SQUARE = 7'b0010000,
    ST_ROOT   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

endpackage

@@ hdl/scan_point_curvature_unit.sv @@
// scan_point_curvature_unit: streaming curvature of points on one lidar scan line.
// Depends on spc_pkg (hdl/spc_pkg.sv).

// The unit takes the points of one scan line, one request at a time, and writes
// each into a ring store of STORE_DEPTH entries (one synchronous memory, one
// write and one registered read port). Nothing leaves the unit until
// MIN_SCAN_POINTS points of a scan have arrived; from then on each new point
// releases the point HALF_WINDOW places behind it, and the request marked
// last_point flushes everything still stored and restarts the ring for the
// next scan. For every released point the sequencer reads the point through
// the single read port; for a point with a curvature it also reads the
// 2*HALF_WINDOW neighbours, forms per axis the neighbour sum minus 2*HALF_WINDOW
// times the point, squares the three differences on one shared multiplier
// and takes a bit-serial integer square root. The first and last HALF_WINDOW
// points of a scan, and every point of a scan shorter than MIN_SCAN_POINTS,
// come out with curvature_valid low and curvature zero. The square root runs
// RW iterations, where RW = COORD_WIDTH + 3 + clog2(HALF_WINDOW+1). The input
// side takes a new request only while the sequencer is idle; a finished result
// waits in the output register, and the sequencer only stalls when a second
// result is ready before the first is taken.

module scan_point_curvature_unit #(
  parameter int HALF_WINDOW     = 5,
  parameter int MIN_SCAN_POINTS = 20,
  parameter int STORE_DEPTH     = 32,
  parameter int COORD_WIDTH     = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] x_mm,
  input  logic signed [COORD_WIDTH-1:0] y_mm,
  input  logic signed [COORD_WIDTH-1:0] z_mm,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x_mm,
  output logic signed [COORD_WIDTH-1:0] out_y_mm,
  output logic signed [COORD_WIDTH-1:0] out_z_mm,
  output logic [spc_pkg::CURV_W-1:0]    curvature,
  output logic                          curvature_valid,
  output logic                          end_of_scan
);
  import spc_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int PW  = $clog2(STORE_DEPTH + 1);
  localparam int SW  = $clog2(MIN_SCAN_POINTS + 1);
  localparam int EW  = $clog2(HALF_WINDOW + 1);
  localparam int OW  = $clog2(HALF_WINDOW + 1) + 1;
  // Difference vector component: bounded by HALF_WINDOW * 2^(COORD_WIDTH+1).
  localparam int DW  = COORD_WIDTH + 2 + $clog2(HALF_WINDOW + 1);
  localparam int SQW = 2 * DW + 2;
  localparam int RW  = SQW / 2;
  localparam int RCW = $clog2(RW);
  localparam int WW  = 3 * COORD_WIDTH;

  // Ring store of points, {z, y, x}.
  logic [WW-1:0] store [STORE_DEPTH];
  logic [WW-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  // Control state.
  state_t                 state;
  logic [AW-1:0]          write_slot;
  logic [AW-1:0]          emit_slot;
  logic [PW-1:0]          pending;
  logic [SW-1:0]          points_seen;
  logic [EW-1:0]          emitted;
  logic                   flush;
  logic                   em_valid;
  logic                   em_end;
  logic signed [OW-1:0]   off;
  logic                   rd_valid;
  logic                   rd_center;
  logic [1:0]             sq_cnt;
  logic                   prod_valid;
  logic [RCW-1:0]         root_cnt;

  // Datapath registers.
  logic [WW-1:0]          ctr_word;
  logic signed [DW-1:0]   acc [3];
  logic [2*DW-1:0]        prod;
  logic [SQW-1:0]         sq_sum;
  logic [SQW-1:0]         root_rem;
  logic [SQW-1:0]         root_res;
  logic [SQW-1:0]         root_bit;

  // Combinational helpers.
  logic                   accept;
  logic                   emit_fire;
  logic                   rd_issue;
  logic                   last_issue;
  logic                   start_valid;
  logic [PW-1:0]          pending_inc;
  logic [SW-1:0]          points_inc;
  logic [AW-1:0]          write_slot_inc;
  logic [AW-1:0]          emit_slot_inc;
  logic signed [AW+1:0]   addr_sum;
  logic signed [AW+1:0]   addr_wrap;
  logic signed [DW-1:0]   acc_add [3];
  logic signed [DW-1:0]   sel;
  logic [DW-1:0]          mag;
  logic [2*DW-1:0]        prod_next;
  logic [SQW-1:0]         radicand;
  logic [SQW-1:0]         trial;
  logic                   root_ge;
  logic [SQW-1:0]         rem_step;
  logic [SQW-1:0]         res_step;
  logic [CURV_W-1:0]      curv_sat;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);
  assign rd_issue  = (state == ST_READ);
  assign last_issue = !em_valid || (off == OW'(HALF_WINDOW));

  assign pending_inc = (pending < PW'(STORE_DEPTH)) ? pending + 1'b1 : pending;
  assign points_inc  = (points_seen < SW'(MIN_SCAN_POINTS)) ? points_seen + 1'b1
                                                             : points_seen;
  assign write_slot_inc = (write_slot == AW'(STORE_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  assign emit_slot_inc  = (emit_slot == AW'(STORE_DEPTH - 1)) ? '0 : emit_slot + 1'b1;

  // Edge points and short scans get no curvature.
  assign start_valid = flush ? ((points_seen == SW'(MIN_SCAN_POINTS)) &&
                                (emitted == EW'(HALF_WINDOW)) &&
                                (pending >= PW'(HALF_WINDOW + 1)))
                             : (emitted == EW'(HALF_WINDOW));

  // Neighbour address: emit slot plus a small signed offset, wrapped once.
  always_comb begin
    addr_sum = $signed({2'b00, emit_slot}) + (AW+2)'(off);
    if (addr_sum < 0) begin
      addr_wrap = addr_sum + (AW+2)'(STORE_DEPTH);
    end else if (addr_sum >= (AW+2)'(STORE_DEPTH)) begin
      addr_wrap = addr_sum - (AW+2)'(STORE_DEPTH);
    end else begin
      addr_wrap = addr_sum;
    end
    rd_addr = addr_wrap[AW-1:0];
  end

  // Accumulate neighbours; the center point enters with weight -2*HALF_WINDOW.
  always_comb begin
    logic signed [COORD_WIDTH-1:0] c;
    logic signed [DW-1:0]          ce;
    logic signed [DW-1:0]          cw;
    for (int a = 0; a < 3; a++) begin
      c  = $signed(rd_data[a*COORD_WIDTH +: COORD_WIDTH]);
      ce = DW'(c);
      cw = DW'(ce * DW'(2 * HALF_WINDOW));
      acc_add[a] = rd_center ? acc[a] - cw : acc[a] + ce;
    end
  end

  // One shared squarer, one axis per cycle.
  always_comb begin
    case (sq_cnt)
      2'd0:    sel = acc[0];
      2'd1:    sel = acc[1];
      2'd2:    sel = acc[2];
      default: sel = '0;
    endcase
    mag       = sel[DW-1] ? DW'(-sel) : DW'(sel);
    prod_next = (2*DW)'(mag) * (2*DW)'(mag);
    radicand  = sq_sum + SQW'(prod);
  end

  // One step of the restoring square root.
  always_comb begin
    trial    = root_res + root_bit;
    root_ge  = (root_rem >= trial);
    rem_step = root_ge ? root_rem - trial : root_rem;
    res_step = root_ge ? (root_res >> 1) + root_bit : (root_res >> 1);
    curv_sat = (root_res > SQW'(CURV_MAX)) ? CURV_MAX : root_res[CURV_W-1:0];
  end

  // Store: write on accept, registered read while the sequencer gathers.
  // A write only happens while idle and reads only afterwards, so no entry is
  // read and written in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      store[write_slot] <= {z_mm, y_mm, x_mm};
    end
    if (rd_issue) begin
      rd_data <= store[rd_addr];
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_slot  <= '0;
      emit_slot   <= '0;
      pending     <= '0;
      points_seen <= '0;
      emitted     <= '0;
      flush       <= 1'b0;
      em_valid    <= 1'b0;
      em_end      <= 1'b0;
      off         <= '0;
      rd_valid    <= 1'b0;
      rd_center   <= 1'b0;
      sq_cnt      <= '0;
      prod_valid  <= 1'b0;
      root_cnt    <= '0;
      out_valid   <= 1'b0;
    end else begin
      rd_valid   <= rd_issue;
      rd_center  <= rd_issue && (off == '0);
      prod_valid <= (state == ST_SQUARE) && (sq_cnt != 2'd3);
      if (out_valid && out_ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            write_slot  <= write_slot_inc;
            pending     <= pending_inc;
            points_seen <= points_inc;
            flush       <= last_point;
            if (last_point || ((points_inc == SW'(MIN_SCAN_POINTS)) &&
                               (pending_inc > PW'(HALF_WINDOW)))) begin
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          em_valid <= start_valid;
          em_end   <= flush && (pending == PW'(1));
          off      <= start_valid ? -(OW'(HALF_WINDOW)) : '0;
          state    <= ST_READ;
        end
        ST_READ: begin
          if (last_issue) begin
            state <= ST_DRAIN;
          end else begin
            off <= off + OW'(1);
          end
        end
        ST_DRAIN: begin
          sq_cnt <= '0;
          state  <= em_valid ? ST_SQUARE : ST_EMIT;
        end
        ST_SQUARE: begin
          if (sq_cnt == 2'd3) begin
            root_cnt <= '0;
            state    <= ST_ROOT;
          end else begin
            sq_cnt <= sq_cnt + 2'd1;
          end
        end
        ST_ROOT: begin
          if (root_cnt == RCW'(RW - 1)) begin
            state <= ST_EMIT;
          end else begin
            root_cnt <= root_cnt + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_valid <= 1'b1;
            if (flush && (pending == PW'(1))) begin
              // End of scan: restart the ring for the next line.
              write_slot  <= '0;
              emit_slot   <= '0;
              pending     <= '0;
              points_seen <= '0;
              emitted     <= '0;
              flush       <= 1'b0;
              state       <= ST_IDLE;
            end else begin
              emit_slot <= emit_slot_inc;
              pending   <= pending - 1'b1;
              if (emitted != EW'(HALF_WINDOW)) begin
                emitted <= emitted + 1'b1;
              end
              state <= (flush || (pending > PW'(HALF_WINDOW + 1))) ? ST_START : ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (state == ST_START) begin
      for (int a = 0; a < 3; a++) begin
        acc[a] <= '0;
      end
      sq_sum <= '0;
    end
    if (rd_valid) begin
      for (int a = 0; a < 3; a++) begin
        acc[a] <= acc_add[a];
      end
      if (rd_center) begin
        ctr_word <= rd_data;
      end
    end
    if (state == ST_SQUARE) begin
      prod <= prod_next;
      if (prod_valid) begin
        sq_sum <= radicand;
      end
      if (sq_cnt == 2'd3) begin
        root_rem <= radicand;
        root_res <= '0;
        root_bit <= SQW'(1) << (SQW - 2);
      end
    end
    if (state == ST_ROOT) begin
      root_rem <= rem_step;
      root_res <= res_step;
      root_bit <= root_bit >> 2;
    end
    if (emit_fire) begin
      out_x_mm        <= $signed(ctr_word[0 +: COORD_WIDTH]);
      out_y_mm        <= $signed(ctr_word[COORD_WIDTH +: COORD_WIDTH]);
      out_z_mm        <= $signed(ctr_word[2*COORD_WIDTH +: COORD_WIDTH]);
      curvature       <= em_valid ? curv_sat : '0;
      curvature_valid <= em_valid;
      end_of_scan     <= em_end;
    end
  end

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for scan_point_curvature_unit.
// Streams scan lines of points, predicts every emitted point and compares it.
// Depends on spc_pkg and hdl/scan_point_curvature_unit.sv.

module tb;

  // Block configuration; the instance below uses the same values.
  localparam int HALF_WIN   = 5;
  localparam int MIN_PTS    = 20;
  localparam int RING_DEPTH = 32;
  localparam int CW         = 20;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 200;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int TAIL_CYCLES   = 100;
  localparam int MAX_REPORTS   = 10;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [spc_pkg::CURV_W-1:0] curv_t;

  localparam coord_t CMAX = 20'sh7FFFF;
  localparam coord_t CMIN = 20'sh80000;
  localparam coord_t ZERO = 20'sh00000;
  localparam coord_t ONE  = 20'sh00001;
  localparam coord_t NEG1 = 20'shFFFFF;
  localparam curv_t  NO_CURV = '0;

  // One emitted point as the block reports it.
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    curv_t  curv;
    logic   curv_ok;
    logic   scan_end;
  } scan_point_t;

  // One input request. When pinned is set, every point that this request
  // releases must carry pin_ok and pin_curv; these values are typed in by hand.
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    logic   pinned;
    logic   pin_ok;
    curv_t  pin_curv;
  } stim_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t x_mm = '0;
  coord_t y_mm = '0;
  coord_t z_mm = '0;
  logic   last_point = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_x_mm;
  coord_t out_y_mm;
  coord_t out_z_mm;
  curv_t  curvature;
  logic   curvature_valid;
  logic   end_of_scan;

  always #5 clk = ~clk;

  scan_point_curvature_unit #(
    .HALF_WINDOW    (HALF_WIN),
    .MIN_SCAN_POINTS(MIN_PTS),
    .STORE_DEPTH    (RING_DEPTH),
    .COORD_WIDTH    (CW)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .x_mm           (x_mm),
    .y_mm           (y_mm),
    .z_mm           (z_mm),
    .last_point     (last_point),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x_mm       (out_x_mm),
    .out_y_mm       (out_y_mm),
    .out_z_mm       (out_z_mm),
    .curvature      (curvature),
    .curvature_valid(curvature_valid),
    .end_of_scan    (end_of_scan)
  );

  // ------------------------------------------------------------------------
  // Scan line predictor: a ring of points, a read and a write position, and
  // the counts that decide when and how points leave.
  // ------------------------------------------------------------------------
  coord_t ring [RING_DEPTH][3];
  int     wr_pos   = 0;
  int     rd_pos   = 0;
  int     stored   = 0;   // points in the ring not yet released
  int     scan_len = 0;   // points of this scan, saturating at MIN_PTS
  int     released = 0;   // points of this scan released, saturating at HALF_WIN

  scan_point_t due_points[$];   // points the block still owes, oldest first

  int points_sent = 0;
  int mismatches  = 0;
  int cycle_count = 0;
  bit calm        = 1'b0;   // set: neither side idles
  bit hold_req    = 1'b0;   // set: sink holds off for HOLD_CYCLES

  // Floor square root, one result bit at a time from the top.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Norm of (neighbour sum - 2*HALF_WIN * point) over the window around slot s.
  function automatic curv_t window_curvature(int s);
    longint dev;
    longint unsigned sq_sum;
    longint unsigned root;
    sq_sum = 0;
    for (int a = 0; a < 3; a++) begin
      dev = -2 * HALF_WIN * longint'(ring[s][a]);
      for (int k = 1; k <= HALF_WIN; k++) begin
        dev += longint'(ring[(s + RING_DEPTH - k) % RING_DEPTH][a]);
        dev += longint'(ring[(s + k) % RING_DEPTH][a]);
      end
      sq_sum += unsigned'(dev * dev);
    end
    root = floor_sqrt(sq_sum);
    // Saturate a root too wide for the port.
    if (root > 64'(spc_pkg::CURV_MAX)) return spc_pkg::CURV_MAX;
    return curv_t'(root);
  endfunction

  // Release the oldest stored point into the list of due points.
  function automatic void release_oldest(logic ok, logic is_end, stim_row_t r);
    scan_point_t p;
    p.x        = ring[rd_pos][0];
    p.y        = ring[rd_pos][1];
    p.z        = ring[rd_pos][2];
    p.curv_ok  = r.pinned ? r.pin_ok : ok;
    p.curv     = r.pinned ? r.pin_curv : (ok ? window_curvature(rd_pos) : NO_CURV);
    p.scan_end = is_end;
    due_points.push_back(p);
    rd_pos = (rd_pos + 1) % RING_DEPTH;
    if (stored > 0) stored--;
    if (released < HALF_WIN) released++;
  endfunction

  // Take one accepted request and queue every point it releases.
  function automatic void track_point(stim_row_t r);
    logic full;
    logic ok;
    ring[wr_pos][0] = r.x;
    ring[wr_pos][1] = r.y;
    ring[wr_pos][2] = r.z;
    wr_pos = (wr_pos + 1) % RING_DEPTH;
    if (stored < RING_DEPTH) stored++;
    if (scan_len < MIN_PTS) scan_len++;
    if (!r.last) begin
      // Once the scan is long enough, trail the input by HALF_WIN points;
      // the first HALF_WIN points of a scan are edge points.
      if (scan_len >= MIN_PTS) begin
        while (stored > HALF_WIN) release_oldest(released >= HALF_WIN, 1'b0, r);
      end
    end else begin
      // Flush the scan: the trailing HALF_WIN points are edge points, and a
      // short scan has no curvature on any point.
      full = (scan_len >= MIN_PTS);
      while (stored > 0) begin
        ok = full && released >= HALF_WIN && stored - 1 >= HALF_WIN;
        release_oldest(ok, stored == 1, r);
      end
      wr_pos   = 0;
      rd_pos   = 0;
      stored   = 0;
      scan_len = 0;
      released = 0;
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  // Directed scans: a single-point scan (edge and short at once), a short
  // scan of four points, then a scan of exactly MIN_PTS points built from
  // full-scale swings, with a lone spike and small values near the middle.
  // Only the short scans carry typed-in results: no curvature anywhere.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMAX, CMIN, ZERO, 1'b1, 1'b1, 1'b0, NO_CURV},
    '{CMIN, CMAX, ZERO, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{ZERO, NEG1, CMIN, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{ONE,  CMAX, NEG1, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMAX, CMIN, CMAX, 1'b1, 1'b1, 1'b0, NO_CURV},
    '{CMAX, CMIN, ZERO, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMIN, CMAX, ZERO, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMAX, CMIN, CMAX, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMIN, CMAX, CMIN, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMAX, CMIN, CMAX, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMIN, CMAX, CMIN, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMAX, CMIN, CMAX, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMIN, CMAX, CMIN, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMAX, CMAX, CMAX, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMAX, CMAX, CMAX, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMIN, CMIN, CMIN, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMAX, CMAX, CMAX, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{ZERO, ZERO, ZERO, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{ONE,  NEG1, ONE,  1'b0, 1'b0, 1'b0, NO_CURV},
    '{NEG1, ONE,  NEG1, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{20'sd12345, -20'sd54321, ZERO, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{20'sd12000, -20'sd54000, ONE,  1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMAX, ZERO, CMIN, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{ZERO, CMIN, CMAX, 1'b0, 1'b0, 1'b0, NO_CURV},
    '{CMIN, CMAX, CMIN, 1'b1, 1'b0, 1'b0, NO_CURV}
  };

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Scan lengths: some short, some right at the threshold, most a little
  // longer, a few longer still, wrapping the ring once or twice.
  function automatic int pick_scan_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return $urandom_range(1, MIN_PTS - 1);
    if (r < 30) return $urandom_range(MIN_PTS, MIN_PTS + 1);
    if (r < 85) return $urandom_range(MIN_PTS + 2, 40);
    return $urandom_range(41, 80);
  endfunction

  // Style 0: full-range noise; 1: a smooth line with jitter; 2: extremes only.
  function automatic coord_t pick_coord(int style, int i, coord_t base, int slope);
    case (style)
      1:       return coord_t'(base + i * slope + int'($urandom_range(0, 16)) - 8);
      2:       return $urandom_range(0, 1) ? CMAX : CMIN;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Drop valid and scramble the idle payload at each falling edge; n sets how long.
  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid   <= 1'b0;
      x_mm       <= coord_t'($urandom);
      y_mm       <= coord_t'($urandom);
      z_mm       <= coord_t'($urandom);
      last_point <= 1'($urandom);
    end
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_point(stim_row_t r);
    if (!calm) idle_input(pick_gap());
    @(negedge clk);
    in_valid   <= 1'b1;
    x_mm       <= r.x;
    y_mm       <= r.y;
    z_mm       <= r.z;
    last_point <= r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_point(r);
    points_sent++;
  endtask

  task automatic send_scan(int len);
    stim_row_t r;
    int        style;
    coord_t    base [3];
    int        slope [3];
    style = $urandom_range(0, 9);
    style = (style < 4) ? 0 : (style < 8) ? 1 : 2;
    for (int a = 0; a < 3; a++) begin
      base[a]  = coord_t'($urandom);
      slope[a] = int'($urandom_range(0, 4000)) - 2000;
    end
    for (int i = 0; i < len; i++) begin
      r.x        = pick_coord(style, i, base[0], slope[0]);
      r.y        = pick_coord(style, i, base[1], slope[1]);
      r.z        = pick_coord(style, i, base[2], slope[2]);
      r.last     = (i == len - 1);
      r.pinned   = 1'b0;
      r.pin_ok   = 1'b0;
      r.pin_curv = NO_CURV;
      send_point(r);
    end
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  task automatic check_output();
    scan_point_t want;
    scan_point_t got;
    got.x        = out_x_mm;
    got.y        = out_y_mm;
    got.z        = out_z_mm;
    got.curv     = curvature;
    got.curv_ok  = curvature_valid;
    got.scan_end = end_of_scan;
    if (due_points.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: point out with none due: x=%0d y=%0d z=%0d curv=%0d ok=%0b end=%0b",
                 $time, got.x, got.y, got.z, got.curv, got.curv_ok, got.scan_end);
    end else begin
      want = due_points.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.curv !== want.curv || got.curv_ok !== want.curv_ok ||
          got.scan_end !== want.scan_end) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: point mismatch", $time);
          $display("  want x=%0d y=%0d z=%0d curv=%0d ok=%0b end=%0b",
                   want.x, want.y, want.z, want.curv, want.curv_ok, want.scan_end);
          $display("  got  x=%0d y=%0d z=%0d curv=%0d ok=%0b end=%0b",
                   got.x, got.y, got.z, got.curv, got.curv_ok, got.scan_end);
        end
      end
    end
  endtask

  // Sink: set ready at the falling edge, take results at the rising edge.
  // A hold request stalls the output for HOLD_CYCLES so the block backs up.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 6) == 0) stall_left = 1 + pick_gap();
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_output();
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[scan_point_curvature_unit] ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) send_point(directed_rows[i]);

    // Back-pressure: hold off the sink while a long scan streams in with no
    // gaps, so results back up in the output register and the input stalls.
    calm     = 1'b1;
    hold_req = 1'b1;
    send_scan(45);

    while (points_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      send_scan(pick_scan_len());
    end

    // Drain: keep the sink ready, wait for every due point, then let the
    // block settle in case it emits something extra.
    calm = 1'b1;
    idle_input(1);
    while (due_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("[scan_point_curvature_unit] OK");
    else $display("[scan_point_curvature_unit] ERROR");
    $finish;
  end

endmodule
